// ===== src/pes_pkg.sv =====
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants for product_except_self
// Word type, result field widths, default capacity, sequencer states and the
// request bundle of the shared multiplier.
// ----------------------------------------------------------------------------
package pes_pkg;

	localparam int WORD_W      = 32;
	localparam int POS_W       = 6;
	localparam int MAX_LEN_DEF = 64;

	typedef logic [WORD_W-1:0] word_t;

	// Request to the shared multiplier: when en is high, the product register
	// takes the low word of a * b at the next edge.
	typedef struct packed {
		logic  en;
		word_t a;
		word_t b;
	} mul_req_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BWD_RD,
		ST_BWD_MUL1,
		ST_BWD_MUL2,
		ST_BWD_SUF,
		ST_EMIT
	} pes_state_t;

endpackage

// ===== src/pes_if.sv =====
// ----------------------------------------------------------------------------
// pes_if: valid/ready channels of product_except_self
// One interface for the element stream and one for the result stream.
// ----------------------------------------------------------------------------
interface pes_in_if import pes_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] element_value;
	logic                     last_element;

	modport source (output valid, element_value, last_element, input ready);
	modport sink (input valid, element_value, last_element, output ready);
endinterface

interface pes_out_if import pes_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] product;
	logic [POS_W-1:0]         position;
	logic                     truncated;
	logic                     last_result;

	modport source (output valid, product, position, truncated, last_result, input ready);
	modport sink (input valid, product, position, truncated, last_result, output ready);
endinterface

// ===== src/pes_mul.sv =====
// ----------------------------------------------------------------------------
// pes_mul: shared 32 x 32 multiplier with registered low-word product
// The product register resets to one so it can serve as the running prefix.
// ----------------------------------------------------------------------------
module pes_mul import pes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output word_t    p_q
);

	word_t prod;

	assign prod = req.a * req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= word_t'(1);
		end else if (req.en) begin
			p_q <= prod;
		end
	end

endmodule

// ===== src/pes_ram.sv =====
// ----------------------------------------------------------------------------
// pes_ram: one-write, one-read word memory with registered read data
// Read data holds its value while no read is issued.
// ----------------------------------------------------------------------------
module pes_ram import pes_pkg::*; #(
	parameter int DEPTH = MAX_LEN_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  word_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output word_t         rdata_q
);

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== src/product_except_self.sv =====
// ----------------------------------------------------------------------------
// product_except_self: product of all other elements of a vector
// Loads a vector one element per transfer, builds exclusive prefix products,
// runs a backward suffix pass on a shared multiplier and emits one result per
// stored element in index order.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload                                   Transfer
//   elements   in         element_value, last_element               valid & ready
//   results    out        product, position, truncated, last_result valid & ready
//
// Elements load back to back with no stall; ready is high only while loading.
// After the last element, the backward pass issues one read (ST_BWD_RD), then
// runs ST_BWD_MUL1, ST_BWD_MUL2 and ST_BWD_SUF for each stored element from the
// last down to the first, since both products of an element go through the one
// multiplier; emission then loads one result whenever the result register is
// free, that is, empty or taken through results.ready.
// The result register parts the two sides: a new vector may load while the
// final result of the previous run still waits. Reset is asynchronous, active
// low; the element and partial memories need no clearing since only entries
// written in the current run are read.
//
module product_except_self import pes_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input logic     clk,
	input logic     arst_n,
	pes_in_if.sink  elements,
	pes_out_if.source results
);

	localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CntW = $clog2(MAX_LEN + 1);

	// Sequencer state and run bookkeeping.
	pes_state_t      state_q, state_d;
	logic [IdxW-1:0] idx_q, idx_d;
	logic [CntW-1:0] count_q, count_d;
	logic            trunc_q, trunc_d;
	word_t           suffix_q, suffix_d;

	// Shared multiplier. Its product register holds the running prefix
	// product while loading and the latest product during the backward pass.
	mul_req_t mul_req;
	word_t    mul_p;

	// Memory ports. Both memories share one read address.
	logic            rd_en;
	logic [IdxW-1:0] rd_addr;
	logic            elem_we;
	logic            part_we;
	logic [IdxW-1:0] part_waddr;
	word_t           elem_rd;
	word_t           part_rd;

	// Result register.
	logic             out_load;
	logic             out_last;
	logic             out_valid_q;
	word_t            out_product_q;
	logic [POS_W-1:0] out_position_q;
	logic             out_trunc_q;
	logic             out_last_q;
	logic             out_free;

	logic accept;
	logic room;

	pes_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.p_q    (mul_p)
	);

	pes_ram #(.DEPTH(MAX_LEN)) u_elem_ram (
		.clk     (clk),
		.we      (elem_we),
		.waddr   (count_q[IdxW-1:0]),
		.wdata   (word_t'(elements.element_value)),
		.re      (rd_en),
		.raddr   (rd_addr),
		.rdata_q (elem_rd)
	);

	pes_ram #(.DEPTH(MAX_LEN)) u_part_ram (
		.clk     (clk),
		.we      (part_we),
		.waddr   (part_waddr),
		.wdata   (mul_p),
		.re      (rd_en),
		.raddr   (rd_addr),
		.rdata_q (part_rd)
	);

	assign elements.ready = (state_q == ST_LOAD);
	assign accept         = elements.valid && elements.ready;
	assign room           = (count_q < CntW'(MAX_LEN));
	assign out_free       = !out_valid_q || results.ready;
	assign out_last       = ((CntW'(idx_q) + CntW'(1)) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			idx_q    <= '0;
			count_q  <= '0;
			trunc_q  <= 1'b0;
			suffix_q <= word_t'(1);
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			count_q  <= count_d;
			trunc_q  <= trunc_d;
			suffix_q <= suffix_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		count_d    = count_q;
		trunc_d    = trunc_q;
		suffix_d   = suffix_q;
		mul_req.en = 1'b0;
		mul_req.a  = mul_p;
		mul_req.b  = word_t'(elements.element_value);
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		elem_we    = 1'b0;
		part_we    = 1'b0;
		part_waddr = count_q[IdxW-1:0];
		out_load   = 1'b0;

		unique case (state_q)
			ST_LOAD: begin
				if (accept) begin
					if (room) begin
						// Store the element and the prefix product before it,
						// then fold the element into the running prefix.
						elem_we    = 1'b1;
						part_we    = 1'b1;
						mul_req.en = 1'b1;
						count_d    = count_q + CntW'(1);
					end else begin
						trunc_d = 1'b1;
					end
					if (elements.last_element) begin
						idx_d    = IdxW'(count_d - CntW'(1));
						suffix_d = word_t'(1);
						state_d  = ST_BWD_RD;
					end
				end
			end
			ST_BWD_RD: begin
				rd_en   = 1'b1;
				state_d = ST_BWD_MUL1;
			end
			ST_BWD_MUL1: begin
				mul_req.en = 1'b1;
				mul_req.a  = part_rd;
				mul_req.b  = suffix_q;
				state_d    = ST_BWD_MUL2;
			end
			ST_BWD_MUL2: begin
				// Prefix times suffix is final; store it and extend the suffix.
				part_we    = 1'b1;
				part_waddr = idx_q;
				mul_req.en = 1'b1;
				mul_req.a  = suffix_q;
				mul_req.b  = elem_rd;
				state_d    = ST_BWD_SUF;
			end
			ST_BWD_SUF: begin
				suffix_d = mul_p;
				rd_en    = 1'b1;
				if (idx_q == '0) begin
					rd_addr = '0;
					state_d = ST_EMIT;
				end else begin
					rd_addr = idx_q - IdxW'(1);
					idx_d   = idx_q - IdxW'(1);
					state_d = ST_BWD_MUL1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (out_last) begin
						// Run complete: back to the reset state of the run.
						count_d    = '0;
						trunc_d    = 1'b0;
						mul_req.en = 1'b1;
						mul_req.a  = word_t'(1);
						mul_req.b  = word_t'(1);
						idx_d      = '0;
						state_d    = ST_LOAD;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + IdxW'(1);
						idx_d   = idx_q + IdxW'(1);
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_product_q  <= part_rd;
			out_position_q <= POS_W'(idx_q);
			out_trunc_q    <= trunc_q;
			out_last_q     <= out_last;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.product     = $signed(out_product_q);
	assign results.position    = out_position_q;
	assign results.truncated   = out_trunc_q;
	assign results.last_result = out_last_q;

`ifndef SYNTHESIS
	// The element count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MAX_LEN))
		else $error("element count above capacity");

	// Once a run is closed it holds at least one stored element.
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LOAD |-> count_q != '0)
		else $error("backward or emit pass with no stored element");

	// Every index used after loading lies inside the stored run.
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LOAD |-> CntW'(idx_q) < count_q)
		else $error("pass index outside the stored run");

	// Results leave in index order.
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_load && !out_last |=> idx_q == $past(idx_q) + IdxW'(1))
		else $error("emit index did not advance by one");
`endif

endmodule
